// ===== rtl/cinv_pkg.sv =====
// shared constants and types for the circle inversion unit
// no dependencies; used by every other file of the block
package cinv_pkg;

    localparam int COORD_WIDTH_DEF = 32;

    localparam logic CMD_CIRCLE = 1'b0;
    localparam logic CMD_POINT  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_RADIUS = 2'd1,
        STATUS_DEGEN  = 2'd2,
        STATUS_SAT    = 2'd3
    } status_t;

    typedef struct packed {
        logic point;
        logic rad_err;
        logic degen;
        logic neg_re;
        logic neg_im;
    } cinv_flags_t;

endpackage

// ===== rtl/cinv_if.sv =====
// valid/ready channel interfaces for the request and result beats
// depends on cinv_pkg for the default coordinate width
interface cinv_in_if #(parameter int COORD_WIDTH = cinv_pkg::COORD_WIDTH_DEF);
    logic                   valid;
    logic                   ready;
    logic                   cmd;
    logic [COORD_WIDTH-1:0] mirror_re;
    logic [COORD_WIDTH-1:0] mirror_im;
    logic [COORD_WIDTH-2:0] mirror_radius;
    logic [COORD_WIDTH-1:0] target_re;
    logic [COORD_WIDTH-1:0] target_im;
    logic [COORD_WIDTH-2:0] target_radius;

    modport source (output valid, cmd, mirror_re, mirror_im, mirror_radius,
                    target_re, target_im, target_radius, input ready);
    modport sink   (input valid, cmd, mirror_re, mirror_im, mirror_radius,
                    target_re, target_im, target_radius, output ready);
endinterface

interface cinv_out_if #(parameter int COORD_WIDTH = cinv_pkg::COORD_WIDTH_DEF);
    logic                   valid;
    logic                   ready;
    logic [COORD_WIDTH-1:0] out_re;
    logic [COORD_WIDTH-1:0] out_im;
    logic [COORD_WIDTH-2:0] out_radius;
    logic [1:0]             status;

    modport source (output valid, out_re, out_im, out_radius, status, input ready);
    modport sink   (input valid, out_re, out_im, out_radius, status, output ready);
endinterface

// ===== rtl/cinv_front.sv =====
// front end: differences, squares, split products and the rounded dividend
// depends on cinv_pkg; four register stages, all advance on en
module cinv_front #(
    parameter int COORD_WIDTH = cinv_pkg::COORD_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic                        cmd,
    input  logic [COORD_WIDTH-1:0]      mirror_re,
    input  logic [COORD_WIDTH-1:0]      mirror_im,
    input  logic [COORD_WIDTH-2:0]      mirror_radius,
    input  logic [COORD_WIDTH-1:0]      target_re,
    input  logic [COORD_WIDTH-1:0]      target_im,
    input  logic [COORD_WIDTH-2:0]      target_radius,
    output logic                        out_valid,
    output cinv_pkg::cinv_flags_t       flags,
    output logic [COORD_WIDTH-1:0]      base_re,
    output logic [COORD_WIDTH-1:0]      base_im,
    output logic [3*COORD_WIDTH:0]      num_re,
    output logic [3*COORD_WIDTH:0]      num_im,
    output logic [3*COORD_WIDTH:0]      num_rad,
    output logic [2*COORD_WIDTH+2:0]    den
);
    localparam int W   = COORD_WIDTH;
    localparam int AW  = W + 1;
    localparam int SQW = 2 * W + 2;
    localparam int RW  = 2 * W - 2;
    localparam int PW  = 2 * W + 1;
    localparam int NW  = 3 * W + 1;

    // stage 1
    logic [AW-1:0]  dx_next, dy_next, ax_next, ay_next;
    logic [W-2:0]   s_next;
    logic           err_next;
    logic           v1_reg, point1_reg, err1_reg, sx1_reg, sy1_reg;
    logic [AW-1:0]  ax1_reg, ay1_reg;
    logic [W-2:0]   r1_reg, s1_reg;
    logic [W-1:0]   mre1_reg, mim1_reg;

    assign dx_next  = {target_re[W-1], target_re} - {mirror_re[W-1], mirror_re};
    assign dy_next  = {target_im[W-1], target_im} - {mirror_im[W-1], mirror_im};
    assign ax_next  = dx_next[AW-1] ? (~dx_next + 1'b1) : dx_next;
    assign ay_next  = dy_next[AW-1] ? (~dy_next + 1'b1) : dy_next;
    assign s_next   = (cmd == cinv_pkg::CMD_POINT) ? '0 : target_radius;
    assign err_next = (mirror_radius == '0)
                   || ((cmd != cinv_pkg::CMD_POINT) && (target_radius == '0));

    // stage 2
    logic           v2_reg, point2_reg, err2_reg, sx2_reg, sy2_reg;
    logic [SQW-1:0] axsq2_reg, aysq2_reg;
    logic [RW-1:0]  ssq2_reg, r2sq2_reg;
    logic [AW-1:0]  ax2_reg, ay2_reg;
    logic [W-2:0]   s2_reg;
    logic [W-1:0]   mre2_reg, mim2_reg;

    // stage 3
    logic [SQW-1:0] sq_next, s2e_next, dmag_next;
    logic           dneg_next;
    logic [W-1:0]   r2lo_next;
    logic [W-3:0]   r2hi_next;
    logic           v3_reg, point3_reg, err3_reg, nre3_reg, nim3_reg;
    logic [SQW-1:0] dmag3_reg;
    logic [PW-1:0]  pxl3_reg, pxh3_reg, pyl3_reg, pyh3_reg, psl3_reg, psh3_reg;
    logic [W-1:0]   mre3_reg, mim3_reg;

    assign sq_next   = axsq2_reg + aysq2_reg;
    assign s2e_next  = SQW'(ssq2_reg);
    assign dneg_next = sq_next < s2e_next;
    assign dmag_next = dneg_next ? (s2e_next - sq_next) : (sq_next - s2e_next);
    assign r2lo_next = r2sq2_reg[W-1:0];
    assign r2hi_next = r2sq2_reg[RW-1:W];

    // stage 4
    logic [NW-1:0]  nx_next, ny_next, ns_next;

    assign nx_next = {pxh3_reg, {W{1'b0}}} + NW'(pxl3_reg);
    assign ny_next = {pyh3_reg, {W{1'b0}}} + NW'(pyl3_reg);
    assign ns_next = {psh3_reg, {W{1'b0}}} + NW'(psl3_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            out_valid <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            point1_reg <= (cmd == cinv_pkg::CMD_POINT);
            err1_reg   <= err_next;
            sx1_reg    <= dx_next[AW-1];
            sy1_reg    <= dy_next[AW-1];
            ax1_reg    <= ax_next;
            ay1_reg    <= ay_next;
            r1_reg     <= mirror_radius;
            s1_reg     <= s_next;
            mre1_reg   <= mirror_re;
            mim1_reg   <= mirror_im;

            point2_reg <= point1_reg;
            err2_reg   <= err1_reg;
            sx2_reg    <= sx1_reg;
            sy2_reg    <= sy1_reg;
            axsq2_reg  <= SQW'(ax1_reg) * SQW'(ax1_reg);
            aysq2_reg  <= SQW'(ay1_reg) * SQW'(ay1_reg);
            ssq2_reg   <= RW'(s1_reg) * RW'(s1_reg);
            r2sq2_reg  <= RW'(r1_reg) * RW'(r1_reg);
            ax2_reg    <= ax1_reg;
            ay2_reg    <= ay1_reg;
            s2_reg     <= s1_reg;
            mre2_reg   <= mre1_reg;
            mim2_reg   <= mim1_reg;

            point3_reg <= point2_reg;
            err3_reg   <= err2_reg;
            nre3_reg   <= sx2_reg ^ dneg_next;
            nim3_reg   <= sy2_reg ^ dneg_next;
            dmag3_reg  <= dmag_next;
            pxl3_reg   <= PW'(r2lo_next) * PW'(ax2_reg);
            pxh3_reg   <= PW'(r2hi_next) * PW'(ax2_reg);
            pyl3_reg   <= PW'(r2lo_next) * PW'(ay2_reg);
            pyh3_reg   <= PW'(r2hi_next) * PW'(ay2_reg);
            psl3_reg   <= PW'(r2lo_next) * PW'(s2_reg);
            psh3_reg   <= PW'(r2hi_next) * PW'(s2_reg);
            mre3_reg   <= mre2_reg;
            mim3_reg   <= mim2_reg;

            flags.point   <= point3_reg;
            flags.rad_err <= err3_reg;
            flags.degen   <= (dmag3_reg == '0);
            flags.neg_re  <= nre3_reg;
            flags.neg_im  <= nim3_reg;
            base_re       <= mre3_reg;
            base_im       <= mim3_reg;
            // round to nearest: (2n + d) / 2d
            num_re        <= {nx_next[NW-2:0], 1'b0} + NW'(dmag3_reg);
            num_im        <= {ny_next[NW-2:0], 1'b0} + NW'(dmag3_reg);
            num_rad       <= {ns_next[NW-2:0], 1'b0} + NW'(dmag3_reg);
            den           <= {dmag3_reg, 1'b0};
        end
    end

endmodule

// ===== rtl/cinv_div.sv =====
// pipelined restoring divider, one quotient bit per stage plus an overflow stage
// depends on cinv_pkg; COORD_WIDTH+2 register stages, all advance on en
module cinv_div #(
    parameter int COORD_WIDTH = cinv_pkg::COORD_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic [3*COORD_WIDTH:0]   num,
    input  logic [2*COORD_WIDTH+2:0] den,
    output logic [COORD_WIDTH:0]     quo,
    output logic                     ovf
);
    localparam int W  = COORD_WIDTH;
    localparam int NW = 3 * W + 1;
    localparam int DW = 2 * W + 3;
    localparam int CW = DW + W + 1;
    localparam int NS = W + 2;

    logic [NW-1:0] rem_reg [NS];
    logic [DW-1:0] den_reg [NS];
    logic [W:0]    q_reg   [NS];
    logic          ovf_reg [NS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= CW'(num) >= {den, {(W+1){1'b0}}};
        end
    end

    for (genvar j = 1; j < NS; j++)
    begin : g_stage
        localparam int SH = W + 1 - j;
        logic [CW-1:0] remx, dsh;
        logic          ge;

        assign remx = CW'(rem_reg[j-1]);
        assign dsh  = CW'(den_reg[j-1]) << SH;
        assign ge   = remx >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= ge ? NW'(remx - dsh) : rem_reg[j-1];
                den_reg[j] <= den_reg[j-1];
                q_reg[j]   <= q_reg[j-1] | ((W+1)'(ge) << SH);
                ovf_reg[j] <= ovf_reg[j-1];
            end
        end
    end

    assign quo = q_reg[NS-1];
    assign ovf = ovf_reg[NS-1];

endmodule

// ===== rtl/circle_inversion_unit_core.sv =====
// circle inversion unit: reflects a circle or a point through a mirror circle
// circle_inversion_unit_core -- top level
// depends on cinv_pkg, cinv_if, cinv_front and cinv_div
//
// req carries one item per beat: cmd, the mirror circle and the target.
// rsp carries one result beat per item, in order: out_re, out_im,
// out_radius and status (ok, bad radius, zero denominator, saturated).
// From request beat to result valid an item passes four front stages,
// COORD_WIDTH + 2 divider stages and one result register. One item is
// taken every cycle while rsp does not stall, as the bit-per-stage
// divider holds one item in each stage. All stages share one advance
// enable, so when rsp stalls the whole pipe holds and req.ready drops;
// nothing is lost or repeated. Reset clears the valid bits only; the
// first request can follow in the next cycle.
module circle_inversion_unit_core #(
    parameter int COORD_WIDTH = cinv_pkg::COORD_WIDTH_DEF
) (
    input logic clk,
    input logic rst_n,
    cinv_in_if.sink    req,
    cinv_out_if.source rsp
);
    localparam int W  = COORD_WIDTH;
    localparam int NW = 3 * W + 1;
    localparam int DW = 2 * W + 3;
    localparam int NS = W + 2;

    localparam logic [W-1:0]        CMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]        CMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W+1:0] SMAX = {3'b000, {(W-1){1'b1}}};
    localparam logic signed [W+1:0] SMIN = {3'b111, {(W-1){1'b0}}};
    localparam logic [W:0]          QLIM = {1'b1, {W{1'b0}}};
    localparam logic [W:0]          RLIM = {2'b00, {(W-1){1'b1}}};

    logic                  en;
    logic                  fr_valid;
    cinv_pkg::cinv_flags_t fr_flags;
    logic [W-1:0]          fr_re, fr_im;
    logic [NW-1:0]         num_re, num_im, num_rad;
    logic [DW-1:0]         den;
    logic [W:0]            q_re, q_im, q_rad;
    logic                  ovf_re, ovf_im, ovf_rad;

    logic [NS-1:0]         sb_valid_reg;
    cinv_pkg::cinv_flags_t sb_flags_reg [NS];
    logic [W-1:0]          sb_re_reg    [NS];
    logic [W-1:0]          sb_im_reg    [NS];

    logic                  out_valid_reg;
    logic [W-1:0]          out_re_reg, out_im_reg;
    logic [W-2:0]          out_rad_reg;
    cinv_pkg::status_t     out_status_reg;

    logic [W:0]            pre_next, pim_next;
    logic                  rbig_next;
    logic [W-1:0]          re_next, im_next;
    logic [W-2:0]          rad_next;
    cinv_pkg::status_t     status_next;
    cinv_pkg::cinv_flags_t fl;

    assign en        = !out_valid_reg || rsp.ready;
    assign req.ready = en;

    cinv_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (req.valid),
        .cmd           (req.cmd),
        .mirror_re     (req.mirror_re),
        .mirror_im     (req.mirror_im),
        .mirror_radius (req.mirror_radius),
        .target_re     (req.target_re),
        .target_im     (req.target_im),
        .target_radius (req.target_radius),
        .out_valid     (fr_valid),
        .flags         (fr_flags),
        .base_re       (fr_re),
        .base_im       (fr_im),
        .num_re        (num_re),
        .num_im        (num_im),
        .num_rad       (num_rad),
        .den           (den)
    );

    cinv_div #(.COORD_WIDTH(COORD_WIDTH)) u_div_re (
        .clk (clk), .en (en), .num (num_re), .den (den), .quo (q_re), .ovf (ovf_re)
    );

    cinv_div #(.COORD_WIDTH(COORD_WIDTH)) u_div_im (
        .clk (clk), .en (en), .num (num_im), .den (den), .quo (q_im), .ovf (ovf_im)
    );

    cinv_div #(.COORD_WIDTH(COORD_WIDTH)) u_div_rad (
        .clk (clk), .en (en), .num (num_rad), .den (den), .quo (q_rad), .ovf (ovf_rad)
    );

    // sideband travels alongside the divider stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sb_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sb_valid_reg  <= {sb_valid_reg[NS-2:0], fr_valid};
            out_valid_reg <= sb_valid_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_flags_reg[0] <= fr_flags;
            sb_re_reg[0]    <= fr_re;
            sb_im_reg[0]    <= fr_im;
            for (int k = 1; k < NS; k++)
            begin
                sb_flags_reg[k] <= sb_flags_reg[k-1];
                sb_re_reg[k]    <= sb_re_reg[k-1];
                sb_im_reg[k]    <= sb_im_reg[k-1];
            end
            out_re_reg     <= re_next;
            out_im_reg     <= im_next;
            out_rad_reg    <= rad_next;
            out_status_reg <= status_next;
        end
    end

    // returns {saturated, coordinate}
    function automatic logic [W:0] place(input logic [W-1:0] base, input logic [W:0] qv,
                                         input logic big, input logic neg);
        logic signed [W+1:0] sum;
        logic [W:0]          res;
        if (neg)
            sum = $signed({base[W-1], base[W-1], base}) - $signed({1'b0, qv});
        else
            sum = $signed({base[W-1], base[W-1], base}) + $signed({1'b0, qv});
        if (big || (qv > QLIM))
            res = {1'b1, (neg ? CMIN : CMAX)};
        else if (sum > SMAX)
            res = {1'b1, CMAX};
        else if (sum < SMIN)
            res = {1'b1, CMIN};
        else
            res = {1'b0, sum[W-1:0]};
        return res;
    endfunction

    assign fl        = sb_flags_reg[NS-1];
    assign pre_next  = place(sb_re_reg[NS-1], q_re, ovf_re, fl.neg_re);
    assign pim_next  = place(sb_im_reg[NS-1], q_im, ovf_im, fl.neg_im);
    assign rbig_next = !fl.point && (ovf_rad || (q_rad > RLIM));

    always_comb
    begin
        re_next     = '0;
        im_next     = '0;
        rad_next    = '0;
        status_next = cinv_pkg::STATUS_OK;
        if (fl.rad_err)
            status_next = cinv_pkg::STATUS_RADIUS;
        else if (fl.degen)
            status_next = cinv_pkg::STATUS_DEGEN;
        else
        begin
            re_next = pre_next[W-1:0];
            im_next = pim_next[W-1:0];
            if (!fl.point)
                rad_next = rbig_next ? CMAX[W-2:0] : q_rad[W-2:0];
            if (pre_next[W] || pim_next[W] || rbig_next)
                status_next = cinv_pkg::STATUS_SAT;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.out_re     = out_re_reg;
    assign rsp.out_im     = out_im_reg;
    assign rsp.out_radius = out_rad_reg;
    assign rsp.status     = out_status_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ((out_status_reg == cinv_pkg::STATUS_RADIUS)
                       || (out_status_reg == cinv_pkg::STATUS_DEGEN))
        |-> (out_re_reg == '0) && (out_im_reg == '0) && (out_rad_reg == '0))
        else $error("error status with nonzero result");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(sb_valid_reg) && $stable(fr_valid))
        else $error("pipeline moved during stall");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready == (!rsp.valid || rsp.ready))
        else $error("ready does not follow output stall");

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for circle_inversion_unit_core: random and directed
// circle/point beats with random stalls on both channels, checked in order
// depends on cinv_pkg, cinv_if and the rtl of the block
`timescale 1ns / 1ps

module testbench;

    localparam int W = cinv_pkg::COORD_WIDTH_DEF;
    localparam longint CMAX = (longint'(1) << (W - 1)) - 1;
    localparam longint CMIN = -CMAX - 1;
    localparam logic [127:0] RMAX = (128'd1 << (W - 1)) - 1;

    typedef struct {
        logic         cmd;
        logic [W-1:0] mirror_re;
        logic [W-1:0] mirror_im;
        logic [W-2:0] mirror_radius;
        logic [W-1:0] target_re;
        logic [W-1:0] target_im;
        logic [W-2:0] target_radius;
    } geom_req_t;

    typedef struct {
        logic [W-1:0]      out_re;
        logic [W-1:0]      out_im;
        logic [W-2:0]      out_radius;
        cinv_pkg::status_t status;
    } geom_rsp_t;

    logic clk;
    logic rst_n;
    cinv_in_if  #(.COORD_WIDTH(W)) req ();
    cinv_out_if #(.COORD_WIDTH(W)) rsp ();

    circle_inversion_unit_core #(.COORD_WIDTH(W)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    geom_req_t pending_q[$];
    geom_rsp_t image_q[$];
    geom_req_t offered;
    int        send_gap = 0;
    int        recv_gap = 0;
    int        hold_cycles = 0;
    int        rsp_count = 0;
    bit        hold_done = 1'b0;
    bit        feed_done;
    bit        failed = 1'b0;

    function automatic longint shift_by(longint base, logic [127:0] q, bit neg,
                                        inout bit sat);
        longint sum;
        if (q > (128'd1 << W))
        begin
            sat = 1'b1;
            return neg ? CMIN : CMAX;
        end
        sum = neg ? base - longint'(q[63:0]) : base + longint'(q[63:0]);
        if (sum > CMAX)
        begin
            sat = 1'b1;
            return CMAX;
        end
        if (sum < CMIN)
        begin
            sat = 1'b1;
            return CMIN;
        end
        return sum;
    endfunction

    function automatic logic [127:0] round_div(logic [127:0] n, logic [127:0] d);
        return ((n << 1) + d) / (d << 1);
    endfunction

    function automatic geom_rsp_t reflect(geom_req_t it);
        geom_rsp_t    res;
        bit           point;
        bit           dneg;
        bit           sat;
        longint       mre, mim, dx, dy, ore, oim;
        logic [127:0] ax, ay, r, s, sq, s2, dmag, r2, q;
        point = (it.cmd == cinv_pkg::CMD_POINT);
        mre = longint'($signed(it.mirror_re));
        mim = longint'($signed(it.mirror_im));
        dx = longint'($signed(it.target_re)) - mre;
        dy = longint'($signed(it.target_im)) - mim;
        ax = 128'(dx < 0 ? -dx : dx);
        ay = 128'(dy < 0 ? -dy : dy);
        r = 128'(it.mirror_radius);
        s = point ? 128'd0 : 128'(it.target_radius);
        sat = 1'b0;
        res.out_re = '0;
        res.out_im = '0;
        res.out_radius = '0;
        if (r == 0 || (!point && s == 0))
        begin
            res.status = cinv_pkg::STATUS_RADIUS;
            return res;
        end
        sq = ax * ax + ay * ay;
        s2 = s * s;
        dneg = sq < s2;
        dmag = dneg ? s2 - sq : sq - s2;
        if (dmag == 0)
        begin
            res.status = cinv_pkg::STATUS_DEGEN;
            return res;
        end
        r2 = r * r;
        ore = shift_by(mre, round_div(r2 * ax, dmag), (dx < 0) != dneg, sat);
        oim = shift_by(mim, round_div(r2 * ay, dmag), (dy < 0) != dneg, sat);
        res.out_re = ore[W-1:0];
        res.out_im = oim[W-1:0];
        if (!point)
        begin
            q = round_div(r2 * s, dmag);
            if (q > RMAX)
            begin
                sat = 1'b1;
                q = RMAX;
            end
            res.out_radius = q[W-2:0];
        end
        res.status = sat ? cinv_pkg::STATUS_SAT : cinv_pkg::STATUS_OK;
        return res;
    endfunction

    function automatic logic [W-1:0] rand_coord(bit near);
        if (near)
            return W'($signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000);
        return W'($urandom);
    endfunction

    function automatic geom_req_t make_beat(logic cmd, longint mre, longint mim,
                                            longint mr, longint tre, longint tim,
                                            longint tr);
        geom_req_t it;
        it.cmd = cmd;
        it.mirror_re = W'(mre);
        it.mirror_im = W'(mim);
        it.mirror_radius = (W-1)'(mr);
        it.target_re = W'(tre);
        it.target_im = W'(tim);
        it.target_radius = (W-1)'(tr);
        return it;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        geom_req_t it;
        int        k;
        longint    one;
        one = longint'(1) << 16;
        feed_done = 1'b0;
        // directed: extremes, both commands, error and degenerate cases
        pending_q = {pending_q, make_beat(cinv_pkg::CMD_CIRCLE, 0, 0, one, 3 * one, 0, one)};
        pending_q = {pending_q, make_beat(cinv_pkg::CMD_POINT, 0, 0, one, 2 * one, one, 0)};
        pending_q = {pending_q, make_beat(cinv_pkg::CMD_CIRCLE, 0, 0, 0, one, one, one)};
        pending_q = {pending_q, make_beat(cinv_pkg::CMD_POINT, 0, 0, 0, one, one, one)};
        pending_q = {pending_q, make_beat(cinv_pkg::CMD_CIRCLE, 0, 0, one, one, one, 0)};
        pending_q = {pending_q, make_beat(cinv_pkg::CMD_POINT, 5, 7, one, 5, 7, one)};
        pending_q = {pending_q, make_beat(cinv_pkg::CMD_POINT, 5, 7, one, 6, 7, 12345)};
        pending_q = {pending_q, make_beat(cinv_pkg::CMD_CIRCLE, 0, 0, one, 3 * one,
                                          4 * one, 5 * one)};
        pending_q = {pending_q, make_beat(cinv_pkg::CMD_CIRCLE, one, one, 2 * one, one,
                                          one, one)};
        pending_q = {pending_q, make_beat(cinv_pkg::CMD_CIRCLE, 0, 0, one, one, 0, 3 * one)};
        pending_q = {pending_q, make_beat(cinv_pkg::CMD_CIRCLE, CMAX, CMAX, CMAX, CMIN,
                                          CMIN, CMAX)};
        pending_q = {pending_q, make_beat(cinv_pkg::CMD_POINT, CMIN, CMIN, CMAX, CMAX,
                                          CMAX, CMAX)};
        pending_q = {pending_q, make_beat(cinv_pkg::CMD_POINT, CMAX, 0, CMAX, CMAX - 1,
                                          0, 0)};
        pending_q = {pending_q, make_beat(cinv_pkg::CMD_POINT, CMIN, 0, CMAX, CMIN + 1,
                                          0, 0)};
        pending_q = {pending_q, make_beat(cinv_pkg::CMD_CIRCLE, 0, 0, CMAX, 1, 0, CMAX)};
        pending_q = {pending_q, make_beat(cinv_pkg::CMD_CIRCLE, 0, 0, 1, CMAX, CMAX, 1)};
        pending_q = {pending_q, make_beat(cinv_pkg::CMD_POINT, -one, -one, one, -3 * one,
                                          one, 0)};
        pending_q = {pending_q, make_beat(cinv_pkg::CMD_CIRCLE, -4, 9, 3, 2, 1, 1)};
        pending_q = {pending_q, make_beat(cinv_pkg::CMD_POINT, 0, 0, 1, 1, 1, 0)};
        pending_q = {pending_q, make_beat(cinv_pkg::CMD_CIRCLE, CMIN, CMAX, one, CMIN,
                                          CMAX - 10, 5)};
        for (k = 0; k < 900; k++)
        begin
            bit near;
            int pick;
            longint m;
            near = ($urandom_range(0, 3) != 0);
            it.cmd = 1'($urandom_range(0, 1));
            it.mirror_re = rand_coord(near);
            it.mirror_im = rand_coord(near);
            it.target_re = rand_coord(near);
            it.target_im = rand_coord(near);
            it.mirror_radius = near ? (W-1)'($urandom_range(1, 32'h0004_0000))
                                    : (W-1)'($urandom);
            it.target_radius = near ? (W-1)'($urandom_range(1, 32'h0004_0000))
                                    : (W-1)'($urandom);
            pick = int'($urandom_range(0, 39));
            if (pick == 0)
                it.mirror_radius = '0;
            else if (pick == 1)
                it.target_radius = '0;
            else if (pick == 2)
            begin
                it.target_re = it.mirror_re;
                it.target_im = it.mirror_im;
            end
            else if (pick == 3)
            begin
                // circle through the mirror center
                m = longint'($urandom_range(1, 4000));
                it.cmd = cinv_pkg::CMD_CIRCLE;
                it.target_re = W'(longint'($signed(it.mirror_re)) + 3 * m);
                it.target_im = W'(longint'($signed(it.mirror_im)) - 4 * m);
                it.target_radius = (W-1)'(5 * m);
            end
            pending_q = {pending_q, it};
        end
        feed_done = 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.cmd <= cinv_pkg::CMD_CIRCLE;
            req.mirror_re <= '0;
            req.mirror_im <= '0;
            req.mirror_radius <= '0;
            req.target_re <= '0;
            req.target_im <= '0;
            req.target_radius <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
                image_q = {image_q, reflect(offered)};
            if (!req.valid || req.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    req.valid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    offered = pending_q.pop_front();
                    req.valid <= 1'b1;
                    req.cmd <= offered.cmd;
                    req.mirror_re <= offered.mirror_re;
                    req.mirror_im <= offered.mirror_im;
                    req.mirror_radius <= offered.mirror_radius;
                    req.target_re <= offered.target_re;
                    req.target_im <= offered.target_im;
                    req.target_radius <= offered.target_radius;
                    send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        geom_rsp_t want;
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                rsp_count = rsp_count + 1;
                if (image_q.size() == 0)
                begin
                    failed = 1'b1;
                    $display("%0t unexpected result re=%h im=%h rad=%h st=%0d", $time,
                             rsp.out_re, rsp.out_im, rsp.out_radius, rsp.status);
                end
                else
                begin
                    want = image_q.pop_front();
                    if (rsp.out_re !== want.out_re || rsp.out_im !== want.out_im ||
                        rsp.out_radius !== want.out_radius || rsp.status !== want.status)
                    begin
                        failed = 1'b1;
                        $display("%0t mismatch expected re=%h im=%h rad=%h st=%0d", $time,
                                 want.out_re, want.out_im, want.out_radius, want.status);
                        $display("%0t          actual   re=%h im=%h rad=%h st=%0d", $time,
                                 rsp.out_re, rsp.out_im, rsp.out_radius, rsp.status);
                    end
                end
            end
            // long hold-off once so the pipe fills and backs up
            if (!hold_done && rsp_count >= 200)
            begin
                hold_done <= 1'b1;
                hold_cycles <= 300;
                rsp.ready <= 1'b0;
            end
            else if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                rsp.ready <= 1'b0;
            end
            else if (!rsp.ready || rsp.valid)
            begin
                if (recv_gap > 0)
                begin
                    recv_gap <= recv_gap - 1;
                    rsp.ready <= 1'b0;
                end
                else
                begin
                    rsp.ready <= 1'b1;
                    recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
                end
            end
        end
    end

    initial
    begin
        @(posedge rst_n);
        while (!(feed_done && pending_q.size() == 0))
            @(posedge clk);
        @(posedge clk);
        while (req.valid || image_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (!failed && image_q.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
